@@ src/sccl_pkg.sv @@
// ----------------------------------------------------------------------------
// sccl_pkg
// Shared constants, types and helpers for the solid column span clipper.
// ----------------------------------------------------------------------------
package sccl_pkg;

    // Default screen width in columns
    localparam int COLUMNS_DEF = 128;

    // Occupancy is stored as words of WORD_W column bits
    localparam int WORD_W = 16;
    localparam int BIT_W  = 4;

    // Column positions: inputs are 8 bits, plus one bit for word stepping
    localparam int POS_W  = 9;
    localparam int COL_W  = 7;
    localparam int COORD_W = 8;

    // Span limit per clip item
    localparam int MAX_SPANS = 64;
    localparam int CNT_W     = $clog2(MAX_SPANS + 1);

    // Item kinds carried on tuser
    localparam logic KIND_CLIP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Lowest set bit: {found, index}
    function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W:0] res;
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, BIT_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

@@ src/sccl_occ_mem.sv @@
// ----------------------------------------------------------------------------
// sccl_occ_mem
// Occupancy word store with a registered read and a per-word valid bit,
// so a clear empties the whole store by resetting every valid bit.
// ----------------------------------------------------------------------------
module sccl_occ_mem
    import sccl_pkg::*;
#(
    parameter int WORDS = 8,
    parameter int AW    = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]  valid_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written words read as open
    assign rd_data = rd_valid_reg ? rdata_reg : '0;

endmodule

@@ src/solid_column_span_clipper_top.sv @@
// Timing: a clip word's first span reaches m_tvalid after acceptance via the read,
// load, find and close steps, then is handed on at the next close or at the end.
// Each run is found and then closed in scan; each further 16-column word crossed
// adds a load and at least one more scan. A held output register stalls the scan.
// Throughput: one item at a time. Reset: synchronous active-low, all columns open.
// ----------------------------------------------------------------------------
// solid_column_span_clipper_top
// Occupancy buffer per screen column. Clip words report each run of open
// columns inside [first, end) as a span and optionally mark them occupied.
// ----------------------------------------------------------------------------
module solid_column_span_clipper_top
    import sccl_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] first_column, [15:8] end_column, [16] solid, [23:17] zero
    input  logic [23:0] s_tdata,
    // [0] kind
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] span_start, [13:7] span_end, [15:14] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    localparam int WORDS = (COLUMNS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [WORD_W-1:0] ONES = '1;

    // input word fields
    logic [COORD_W-1:0] in_first;
    logic [COORD_W-1:0] in_end;
    logic               in_solid;
    logic [POS_W-1:0]   end_clamped;

    assign in_first = s_tdata[COORD_W-1:0];
    assign in_end   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_solid = s_tdata[2*COORD_W];

    // end clamp; with wide screens the 8-bit end never exceeds the width
    assign end_clamped = (int'(in_end) > COLUMNS) ? POS_W'(COLUMNS)
                                                  : POS_W'(in_end);

    // control and item state
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic               solid_reg, solid_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               in_run_reg, in_run_next;
    logic [COL_W-1:0]   run_start_reg, run_start_next;
    logic [WORD_W-1:0]  wbuf_reg, wbuf_next;

    // one span held back until we know whether it is the last
    logic               pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0]   pend_start_reg, pend_start_next;
    logic [COL_W-1:0]   pend_end_reg, pend_end_next;

    // output register
    logic               m_valid_reg;
    logic [COL_W-1:0]   m_start_reg, m_end_reg;
    logic               m_last_reg;
    logic               out_free;
    logic               push;
    logic [COL_W-1:0]   push_start, push_end;
    logic               push_last;

    // store access
    logic               mem_clear;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    // scan datapath
    logic [POS_W-1:0]   base;
    logic [POS_W-1:0]   next_base;
    logic [POS_W-1:0]   w_last;
    logic [BIT_W-1:0]   lo;
    logic               end_in_word;
    logic [WORD_W-1:0]  lo_mask, lim_mask, open_m, closed_m, mark_m;
    logic [BIT_W:0]     f_res, z_res;
    logic [POS_W-1:0]   f_pos, z_pos, z_last;
    logic               leave, fin;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign base      = {col_reg[POS_W-1:BIT_W], {BIT_W{1'b0}}};
    assign next_base = base + POS_W'(WORD_W);
    // last column of the current word
    assign w_last    = next_base - POS_W'(1);
    assign lo        = col_reg[BIT_W-1:0];

    // range limits inside the current word
    assign end_in_word = (end_reg[POS_W-1:BIT_W] == col_reg[POS_W-1:BIT_W]);
    assign lo_mask     = ONES << lo;
    assign lim_mask    = end_in_word
                       ? WORD_W'(((WORD_W+1)'(1) << end_reg[BIT_W-1:0]) - (WORD_W+1)'(1))
                       : ONES;
    assign open_m      = ~wbuf_reg & lo_mask & lim_mask;
    // anything not open from the scan position on ends a run
    assign closed_m    = ~open_m & lo_mask;

    assign f_res  = first_set(open_m);
    assign z_res  = first_set(closed_m);
    assign f_pos  = base + POS_W'(f_res[BIT_W-1:0]);
    assign z_pos  = base + POS_W'(z_res[BIT_W-1:0]);
    // a run may end on the last column of the previous word
    assign z_last = z_pos - POS_W'(1);
    assign mark_m = lo_mask & ~(ONES << z_res[BIT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_run_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            in_run_reg     <= in_run_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        col_reg        <= col_next;
        end_reg        <= end_next;
        solid_reg      <= solid_next;
        run_start_reg  <= run_start_next;
        wbuf_reg       <= wbuf_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        if (push) begin
            m_start_reg <= push_start;
            m_end_reg   <= push_end;
            m_last_reg  <= push_last;
        end
    end

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        end_next        = end_reg;
        solid_next      = solid_reg;
        cnt_next        = cnt_reg;
        in_run_next     = in_run_reg;
        run_start_next  = run_start_reg;
        wbuf_next       = wbuf_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        push            = 1'b0;
        push_start      = pend_start_reg;
        push_end        = pend_end_reg;
        push_last       = 1'b0;
        mem_clear       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = AW'(col_reg >> BIT_W);
        wr_en           = 1'b0;
        wr_addr         = AW'(col_reg >> BIT_W);
        leave           = 1'b0;
        fin             = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_CLEAR) begin
                        mem_clear = 1'b1;
                    end else if (POS_W'(in_first) < end_clamped) begin
                        col_next        = POS_W'(in_first);
                        end_next        = end_clamped;
                        solid_next      = in_solid;
                        cnt_next        = '0;
                        in_run_next     = 1'b0;
                        pend_valid_next = 1'b0;
                        rd_en           = 1'b1;
                        rd_addr         = AW'(in_first >> BIT_W);
                        state_next      = ST_LOAD;
                    end
                end
            end

            ST_LOAD: begin
                wbuf_next  = rd_data;
                state_next = ST_SCAN;
            end

            ST_SCAN: begin
                if (!in_run_reg) begin
                    if (cnt_reg == CNT_W'(MAX_SPANS)) begin
                        fin = 1'b1;
                    end else if (f_res[BIT_W]) begin
                        col_next       = f_pos;
                        run_start_next = f_pos[COL_W-1:0];
                        in_run_next    = 1'b1;
                    end else begin
                        leave = 1'b1;
                    end
                end else if (z_res[BIT_W]) begin
                    // run closes here; stall only if a held span cannot go out
                    if (!pend_valid_reg || out_free) begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_start_next = run_start_reg;
                        pend_end_next   = z_last[COL_W-1:0];
                        cnt_next        = cnt_reg + CNT_W'(1);
                        in_run_next     = 1'b0;
                        col_next        = z_pos;
                        if (solid_reg) begin
                            wbuf_next = wbuf_reg | mark_m;
                        end
                    end
                end else if (next_base < end_reg) begin
                    // run carries into the next word
                    if (solid_reg) begin
                        wbuf_next = wbuf_reg | lo_mask;
                    end
                    leave = 1'b1;
                end else if (!pend_valid_reg || out_free) begin
                    // range ends on this word's boundary, so the run closes here
                    push            = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_start_next = run_start_reg;
                    pend_end_next   = w_last[COL_W-1:0];
                    cnt_next        = cnt_reg + CNT_W'(1);
                    in_run_next     = 1'b0;
                    if (solid_reg) begin
                        wbuf_next = wbuf_reg | lo_mask;
                    end
                    leave = 1'b1;
                end

                if (leave || fin) begin
                    wr_en = solid_reg;
                    if (leave && (next_base < end_reg)) begin
                        col_next   = next_base;
                        rd_en      = 1'b1;
                        rd_addr    = AW'(next_base >> BIT_W);
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN: begin
                if (pend_valid_reg) begin
                    if (out_free) begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sccl_occ_mem #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_occ_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mem_clear),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wbuf_next)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_end_reg, m_start_reg};
    assign m_tlast  = m_last_reg;

endmodule
